// ===== design/i2crrs_pkg.sv =====
// Shared types and codes for the I2C register-read sequencer.
package i2crrs_pkg;

    // Sequencer phases, one per poll step of a register read.
    localparam logic [3:0] PH_DEV_WR    = 4'd0;
    localparam logic [3:0] PH_WAIT_DEV  = 4'd1;
    localparam logic [3:0] PH_SEND_REG  = 4'd2;
    localparam logic [3:0] PH_WAIT_REG  = 4'd3;
    localparam logic [3:0] PH_DEV_RD    = 4'd4;
    localparam logic [3:0] PH_WAIT_RD   = 4'd5;
    localparam logic [3:0] PH_RX_SETUP  = 4'd6;
    localparam logic [3:0] PH_WAIT_BYTE = 4'd7;
    localparam logic [3:0] PH_TAKE_BYTE = 4'd8;

    // Bus condition codes.
    localparam logic [1:0] COND_NONE    = 2'd0;
    localparam logic [1:0] COND_START   = 2'd1;
    localparam logic [1:0] COND_RESTART = 2'd2;
    localparam logic [1:0] COND_STOP    = 2'd3;

    // Direction codes.
    localparam logic [1:0] DIR_KEEP = 2'd0;
    localparam logic [1:0] DIR_TX   = 2'd1;
    localparam logic [1:0] DIR_RX   = 2'd2;

    // Acknowledge codes.
    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
    localparam logic [1:0] CFG_REG_ADDR  = 2'd1;
    localparam logic [1:0] CFG_READ_CNT  = 2'd2;

    // Read bit OR-ed into the device address for the read phase.
    localparam logic [7:0] READ_BIT = 8'h01;

    // Width of the packed output word.
    localparam int unsigned OUT_DATA_W = 40;

    typedef struct packed {
        logic [3:0] phase;
        logic [7:0] bytes_received;
        logic       last_pending;
    } t_state;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] read_count;
    } t_cfg;

    typedef struct packed {
        logic       clear_flag;
        logic [1:0] bus_condition;
        logic [1:0] direction_set;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       dummy_read;
        logic [1:0] ack_select;
        logic       data_valid;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic       done_res;
    } t_result;

endpackage

// ===== design/i2c_register_read_sequencer_top.sv =====
// Top level of the I2C register-read sequencer with its stream ports and registers.
//
// Usage: each input word is one poll of a byte-level I2C master engine,
// carrying its transfer-complete flag and data register. For every poll the
// block returns exactly one output word with the commands to issue that
// cycle (flag clear, bus condition, direction, transmit byte, dummy read,
// ack choice) and any received byte with its index; tlast marks the word
// that carries the final byte of a read together with the stop.
// The user must set device address, register address and read count through
// the write port only while the block is idle; the block itself does not
// enforce this. Each takes effect at once. The output word is registered: it
// appears in the cycle after its input word is accepted, the poll being handled
// by the step logic between the state and output registers. One word per cycle unless the receiver stalls.
// Reset (synchronous, active low) clears the state to the start of a
// transaction, the registers to address zero and read count one, and
// empties the output register.
// When the receiver stalls, the output word holds and s_tready drops until
// the word is taken; a word may be accepted in the cycle the old one leaves.
module i2c_register_read_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // Poll input: [0] transfer_done, [8:1] rx_byte, [15:9] zero.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,
    // Result: [0] clear_flag, [2:1] bus_condition, [4:3] direction_set,
    // [5] tx_valid, [13:6] tx_byte, [14] dummy_read, [16:15] ack_select,
    // [17] data_valid, [25:18] data_byte, [33:26] data_index, [39:34] zero.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [i2crrs_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // done_res: last byte taken and stop issued.
    output logic        o_m_tlast
);
    import i2crrs_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    s_accept;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address   <= 8'd0;
            r_cfg.register_address <= 8'd0;
            r_cfg.read_count       <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEV_ADDR: r_cfg.device_address   <= i_cfg_data;
                CFG_REG_ADDR: r_cfg.register_address <= i_cfg_data;
                CFG_READ_CNT: r_cfg.read_count       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Poll step logic.
    i2crrs_step u_step (
        .i_state         (r_state),
        .i_cfg           (r_cfg),
        .i_transfer_done (i_s_tdata[0]),
        .i_rx_byte       (i_s_tdata[8:1]),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    // Sequencer state advances once per accepted poll.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_DEV_WR;
            r_state.bytes_received <= 8'd0;
            r_state.last_pending   <= 1'b0;
        end else if (s_accept) begin
            r_state <= n_state;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= i_s_tvalid;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_result.done_res;
    assign o_m_tdata  = {6'd0,
                         r_result.data_index,
                         r_result.data_byte,
                         r_result.data_valid,
                         r_result.ack_select,
                         r_result.dummy_read,
                         r_result.tx_byte,
                         r_result.tx_valid,
                         r_result.direction_set,
                         r_result.bus_condition,
                         r_result.clear_flag};

    // The phase never reaches the unused codes.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase <= PH_TAKE_BYTE)
        else $error("sequencer phase outside the used range");

    // A finished transaction always carries a byte and a stop.
    a_done_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.done_res) |->
            (r_result.data_valid && r_result.bus_condition == COND_STOP))
        else $error("done word without byte or stop");

    // A new transaction starts with no bytes counted.
    a_fresh_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DEV_WR) |->
            (r_state.bytes_received == 8'd0 && !r_state.last_pending))
        else $error("byte count not cleared at transaction start");

    // A stalled output word blocks new polls.
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("poll accepted while output word stalled");

endmodule

// ===== design/i2crrs_step.sv =====
// One poll of the sequencer: next state and the commands for this poll.
module i2crrs_step (
    input  i2crrs_pkg::t_state  i_state,
    input  i2crrs_pkg::t_cfg    i_cfg,
    input  logic                i_transfer_done,
    input  logic [7:0]          i_rx_byte,
    output i2crrs_pkg::t_state  o_state,
    output i2crrs_pkg::t_result o_result
);
    import i2crrs_pkg::*;

    logic last_now;

    // The byte about to be received is the last one when its index is count minus one.
    assign last_now = (i_state.bytes_received == (i_cfg.read_count - 8'd1));

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (i_state.phase)
            PH_DEV_WR: begin
                o_result.direction_set = DIR_TX;
                o_result.bus_condition = COND_START;
                o_result.tx_valid      = 1'b1;
                o_result.tx_byte       = i_cfg.device_address;
                o_state.phase          = PH_WAIT_DEV;
            end
            PH_WAIT_DEV: begin
                if (i_transfer_done) begin
                    o_result.clear_flag = 1'b1;
                    o_state.phase       = PH_SEND_REG;
                end
            end
            PH_SEND_REG: begin
                o_result.tx_valid = 1'b1;
                o_result.tx_byte  = i_cfg.register_address;
                o_state.phase     = PH_WAIT_REG;
            end
            PH_WAIT_REG: begin
                if (i_transfer_done) begin
                    o_result.clear_flag = 1'b1;
                    o_state.phase       = PH_DEV_RD;
                end
            end
            PH_DEV_RD: begin
                o_result.bus_condition = COND_RESTART;
                o_result.tx_valid      = 1'b1;
                o_result.tx_byte       = i_cfg.device_address | READ_BIT;
                o_state.phase          = PH_WAIT_RD;
            end
            PH_WAIT_RD: begin
                if (i_transfer_done) begin
                    o_result.clear_flag    = 1'b1;
                    o_result.direction_set = DIR_RX;
                    o_state.phase          = PH_RX_SETUP;
                end
            end
            PH_RX_SETUP: begin
                o_state.last_pending = last_now;
                o_result.ack_select  = last_now ? ACK_NACK : ACK_ACK;
                o_result.dummy_read  = 1'b1;
                o_state.phase        = PH_WAIT_BYTE;
            end
            PH_WAIT_BYTE: begin
                if (i_transfer_done) begin
                    o_result.clear_flag = 1'b1;
                    o_state.phase       = PH_TAKE_BYTE;
                end
            end
            PH_TAKE_BYTE: begin
                o_result.data_valid = 1'b1;
                o_result.data_byte  = i_rx_byte;
                o_result.data_index = i_state.bytes_received;
                if (i_state.last_pending) begin
                    o_result.bus_condition = COND_STOP;
                    o_result.done_res      = 1'b1;
                    o_state.bytes_received = '0;
                    o_state.last_pending   = 1'b0;
                    o_state.phase          = PH_DEV_WR;
                end else begin
                    o_state.bytes_received = i_state.bytes_received + 8'd1;
                    o_state.phase          = PH_RX_SETUP;
                end
            end
            default: begin
                // Unused phase codes fall back to the start of a transaction.
                o_state.phase = PH_DEV_WR;
            end
        endcase
    end

endmodule
